>>> rtl/b2d_pkg.sv
package b2d_pkg;

    localparam int VALUE_W   = 128;
    localparam int HALF_W    = 64;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 6;
    localparam int BIT_CNT_W = 7;

    localparam logic [BIT_CNT_W-1:0] LAST_BIT   = 7'd127;
    localparam logic [CHAR_W-1:0]    ASCII_ZERO = 6'd48;
    localparam logic [DIGIT_W:0]     DIGIT_BASE = 5'd10;

    // controller to datapath
    typedef struct packed {
        logic load;      // take a new value, clear the digit row
        logic dbl;       // double the digit row and shift in the next bit
        logic shift_up;  // move the digit row one place toward the top
        logic emit;      // put the top digit into the output register
        logic last;      // the emitted digit is the final one
    } b2d_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic top_zero;  // top digit of the row is zero
        logic out_free;  // output register can take a digit this cycle
    } b2d_sts_t;

endpackage

>>> rtl/binary128_to_decimal_digits_top.sv
// 128-bit unsigned binary to decimal ascii converter. a value is taken as one
// slave transaction (value_high in tdata[63:0], value_low in tdata[127:64])
// and comes back as a run of master transactions, one ascii digit '0'..'9'
// each, most significant first, leading zeros dropped (zero gives a single
// '0'), tlast on the units digit. a conversion loads the value, runs
// double-dabble over all 128 input bits in a single bit-serial doubling row
// (one input bit per cycle into DECIMAL_DIGITS bcd digits), shifts out
// leading zeros, then emits the digits, each only once the output register
// is free. one value is worked at a time; the next value is taken once the
// final digit sits in the output register.
module binary128_to_decimal_digits_top
    import b2d_pkg::*;
#(
    parameter int DECIMAL_DIGITS = 39
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [127:0]   s_tdata,   // value_high [63:0], value_low [127:64]
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // digit_char [5:0], zero pad [7:6]
    output logic           m_tlast    // last_digit
);

    b2d_cmd_t          cmd;
    b2d_sts_t          sts;
    logic [CHAR_W-1:0] digit_char;

    // sequencing: load, bit loop, zero skip, digit emission
    b2d_controller #(
        .DECIMAL_DIGITS (DECIMAL_DIGITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // value shifter, bcd digit row and output register
    b2d_datapath #(
        .DECIMAL_DIGITS (DECIMAL_DIGITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .value_high (s_tdata[HALF_W-1:0]),
        .value_low  (s_tdata[2*HALF_W-1:HALF_W]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_char   (digit_char),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{(8-CHAR_W){1'b0}}, digit_char};

endmodule

>>> rtl/b2d_datapath.sv
module b2d_datapath
    import b2d_pkg::*;
#(
    parameter int DECIMAL_DIGITS = 39
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  b2d_cmd_t                  cmd,
    output b2d_sts_t                  sts,
    input  logic [HALF_W-1:0]         value_high,
    input  logic [HALF_W-1:0]         value_low,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [CHAR_W-1:0]         out_char,
    output logic                      out_last
);

    logic [VALUE_W-1:0]                    value_reg;
    logic [VALUE_W-1:0]                    value_next;
    logic [DECIMAL_DIGITS-1:0][DIGIT_W-1:0] digit_reg;
    logic [DECIMAL_DIGITS-1:0][DIGIT_W-1:0] digit_next;
    logic [DECIMAL_DIGITS-1:0][DIGIT_W-1:0] digit_dbl;
    logic [DECIMAL_DIGITS-1:0]              carry;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic [CHAR_W-1:0]                      out_char_reg;
    logic                                   out_last_reg;
    logic [DIGIT_W-1:0]                     top_digit;

    assign top_digit = digit_reg[DECIMAL_DIGITS-1];

    // carry out of a digit depends only on that digit (2d+c >= 10 iff d >= 5)
    always_comb
    begin
        logic [DIGIT_W:0] sum;
        logic             cin;
        for (int i = 0; i < DECIMAL_DIGITS; i++)
        begin
            cin = (i == 0) ? value_reg[VALUE_W-1] : carry[(i == 0) ? 0 : i-1];
            sum = {digit_reg[i], cin};
            carry[i] = (sum >= DIGIT_BASE);
            if (carry[i])
            begin
                sum = sum - DIGIT_BASE;
            end
            digit_dbl[i] = sum[DIGIT_W-1:0];
        end
    end

    always_comb
    begin
        value_next = value_reg;
        digit_next = digit_reg;
        priority if (cmd.load)
        begin
            value_next = {value_high, value_low};
            digit_next = '0;
        end
        else if (cmd.dbl)
        begin
            value_next = {value_reg[VALUE_W-2:0], 1'b0};
            digit_next = digit_dbl;
        end
        else if (cmd.shift_up)
        begin
            digit_next = {digit_reg[DECIMAL_DIGITS-2:0], {DIGIT_W{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        digit_reg <= digit_next;
    end

    // output register
    always_comb
    begin
        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg <= {{(CHAR_W-DIGIT_W){1'b0}}, top_digit} + ASCII_ZERO;
            out_last_reg <= cmd.last;
        end
    end

    assign sts.top_zero = (top_digit == '0);
    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign out_last     = out_last_reg;

endmodule

>>> rtl/b2d_controller.sv
module b2d_controller
    import b2d_pkg::*;
#(
    parameter int DECIMAL_DIGITS = 39
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  b2d_sts_t sts,
    output b2d_cmd_t cmd
);

    localparam int CNT_W = $clog2(DECIMAL_DIGITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 cnt_one;

    assign cnt_one = (cnt_reg == CNT_W'(1));

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.dbl      = 1'b1;
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == LAST_BIT)
                begin
                    cnt_next   = CNT_W'(DECIMAL_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, always keep the units digit
                if (sts.top_zero && !cnt_one)
                begin
                    cmd.shift_up = 1'b1;
                    cnt_next     = cnt_reg - CNT_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.shift_up = 1'b1;
                    cmd.last     = cnt_one;
                    cnt_next     = cnt_reg - CNT_W'(1);
                    if (cnt_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            cnt_reg     <= cnt_next;
        end
    end

    a_cnt_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SKIP || state_reg == ST_EMIT) |-> cnt_reg != '0)
        else $error("digit count empty while skipping or emitting");

    a_last_ends_run : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> state_reg == ST_IDLE)
        else $error("final digit emitted but controller not idle");

    a_skip_entry : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SKIP && $past(state_reg) == ST_CONV)
        |-> cnt_reg == CNT_W'(DECIMAL_DIGITS))
        else $error("digit count not reloaded after conversion");

    a_load_clears_bits : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_CONV && bit_cnt_reg == '0))
        else $error("conversion did not start at the first bit");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import b2d_pkg::*;

    localparam int  CLK_HALF      = 6;
    localparam int  RESET_CYCLES  = 2;
    localparam int  RANDOM_VALUES = 150;
    localparam int  DRAIN_CYCLES  = 200;       // covers a load, the doubling steps and the leading-zero skip
    localparam int  CYCLE_LIMIT   = 1_500_000; // far beyond the slowest legal run
    localparam int  MAX_DIGITS    = 39;

    // one expected digit transaction on the master side
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;   // value_high [63:0], value_low [127:64]
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;   // digit_char [5:0], zero pad [7:6]
    logic         m_tlast;   // last_digit

    binary128_to_decimal_digits_top u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // digits still owed by the block, oldest first
    digit_t       pending_digits[$];

    // directed stimulus table: value and, where obvious, its decimal text
    logic [127:0] dir_value[$];
    string        dir_text[$];

    int           errors;
    int           values_sent;
    int           digits_seen;
    int           run_len;
    int           longest_run;
    longint       cycles;
    bit           no_idle;

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles, %0d digits outstanding",
                     $time, cycles, pending_digits.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic logic [127:0] pow10(input int k);
        logic [127:0] p;
        p = 128'd1;
        for (int i = 0; i < k; i++)
            p = p * 128'd10;
        return p;
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // repeated division by ten, collected least significant first, then
    // queued most significant first with tlast on the units digit
    function automatic void queue_decimal(input logic [127:0] value);
        logic [127:0] rest;
        logic [3:0]   rev[$];
        digit_t       d;
        rest = value;
        do
        begin
            rev.push_back(4'(rest % 128'd10));
            rest = rest / 128'd10;
        end
        while (rest != 128'd0);
        for (int i = rev.size() - 1; i >= 0; i--)
        begin
            d.ch   = ASCII_ZERO + CHAR_W'(rev[i]);
            d.last = (i == 0);
            pending_digits.push_back(d);
        end
    endfunction

    // hand-written expectation straight from the decimal text
    function automatic void queue_text(input string text);
        digit_t d;
        for (int i = 0; i < text.len(); i++)
        begin
            d.ch   = CHAR_W'(text[i]);
            d.last = (i == text.len() - 1);
            pending_digits.push_back(d);
        end
    endfunction

    // ------------------------------------------------------------------
    // idling
    // ------------------------------------------------------------------

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic int sender_gap();
        if (no_idle || $urandom_range(0, 99) < 50)
            return 0;
        return gap_len();
    endfunction

    // receiver: random stalls on tready, no new ones while no_idle is set
    initial
    begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 20)
                    stall = gap_len();
            end
        end
    end

    // ------------------------------------------------------------------
    // checking of master transactions
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        digit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            digits_seen++;
            run_len++;
            if (pending_digits.size() == 0)
            begin
                errors++;
                $display("%0t unexpected digit: expected none, actual char %0d last %0b",
                         $time, m_tdata[CHAR_W-1:0], m_tlast);
            end
            else
            begin
                want = pending_digits.pop_front();
                if (m_tdata !== {2'b00, want.ch})
                begin
                    errors++;
                    $display("%0t digit_char mismatch: expected %0d actual %0d (tdata %h)",
                             $time, want.ch, m_tdata[CHAR_W-1:0], m_tdata);
                end
                if (m_tlast !== want.last)
                begin
                    errors++;
                    $display("%0t last_digit mismatch: expected %0b actual %0b",
                             $time, want.last, m_tlast);
                end
            end
            if (m_tlast === 1'b1)
            begin
                if (run_len > longest_run)
                    longest_run = run_len;
                run_len = 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // assumes we stand at a falling edge; returns at the falling edge after
    // the slave transaction, with tvalid still high for a back-to-back item
    task automatic send_value(input logic [127:0] value, input string text);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value[63:0], value[127:64]};
        do
        begin
            @(posedge clk);
        end
        while (s_tready !== 1'b1);
        if (text.len() > 0)
            queue_text(text);
        else
            queue_decimal(value);
        values_sent++;
        @(negedge clk);
    endtask

    // hold the sender off until every owed digit has come back
    task automatic wait_all_digits();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_digits.size() != 0)
            @(negedge clk);
    endtask

    task automatic add_row(input logic [63:0] hi, input logic [63:0] lo, input string text);
        dir_value.push_back({hi, lo});
        dir_text.push_back(text);
    endtask

    initial
    begin
        logic [127:0] v;
        int           kind;
        int           k;
        int           n_directed;

        errors      = 0;
        values_sent = 0;
        digits_seen = 0;
        run_len     = 0;
        longest_run = 0;
        cycles      = 0;
        no_idle     = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;

        // directed table: empty text means the predictor supplies the digits
        add_row(64'd0, 64'd0, "0");                                // zero, single digit
        add_row(64'd0, 64'd1, "1");
        add_row(64'd0, 64'd9, "9");
        add_row(64'd0, 64'd10, "10");
        add_row(64'd0, 64'd99, "");
        add_row(64'd0, 64'd100, "");
        add_row(64'd0, '1, "18446744073709551615");              // low half all ones
        add_row(64'd1, 64'd0, "18446744073709551616");           // carry into high half
        add_row(64'd1, '1, "");
        add_row('1, '1, "340282366920938463463374607431768211455"); // 39 digits
        add_row(64'h8000_0000_0000_0000, 64'd0, "");             // top bit alone
        add_row(64'd0, 64'h8000_0000_0000_0000, "");
        add_row(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, "");
        add_row(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, "");
        add_row('1, 64'd0, "");
        add_row(64'd0, 64'hFFFF_FFFF_0000_0000, "");
        v = pow10(19) - 128'd1;  add_row(v[127:64], v[63:0], "");
        v = pow10(19);           add_row(v[127:64], v[63:0], "");
        v = pow10(20);           add_row(v[127:64], v[63:0], "");
        v = pow10(38) - 128'd1;  add_row(v[127:64], v[63:0], "");
        v = pow10(38);           add_row(v[127:64], v[63:0], "");  // 1 and 38 zeros
        v = pow10(38) + 128'd1;  add_row(v[127:64], v[63:0], "");  // zeros inside
        n_directed = dir_value.size();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_value[i])
            send_value(dir_value[i], dir_text[i]);

        // quiet point: everything owed must arrive before going on
        wait_all_digits();

        for (int i = 0; i < RANDOM_VALUES; i++)
        begin
            // a stretch with no idling on either side
            no_idle = (i >= 60 && i < 90);
            kind    = $urandom_range(0, 99);
            if (kind < 30)
            begin
                v = rand128();                                   // full width
            end
            else if (kind < 55)
            begin
                k = $urandom_range(1, 128);                      // random bit length
                v = rand128() & ({128{1'b1}} >> (128 - k));
            end
            else if (kind < 75)
            begin
                k = $urandom_range(1, 38);                       // random digit count
                v = rand128() % pow10(k);
            end
            else if (kind < 90)
            begin
                k = $urandom_range(0, 38);                       // around powers of ten
                v = pow10(k) + 128'($urandom_range(0, 2)) - 128'd1;
            end
            else
            begin
                v = 128'($urandom_range(0, 20));                 // tiny values
            end
            send_value(v, "");
            if ($urandom_range(0, 24) == 0)
                wait_all_digits();
        end
        no_idle = 1'b0;

        wait_all_digits();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d values (%0d from the directed table), checked %0d digits,",
                 values_sent, n_directed, digits_seen);
        $display("longest run %0d of %0d digits, %0d cycles", longest_run, MAX_DIGITS,
                 cycles);
        if (errors == 0 && pending_digits.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
